### design/wtk_pkg.sv
package wtk_pkg;

  localparam int NUM_WORDS   = 256;
  localparam int WORD_BITS   = 8;
  localparam int NUM_BUCKETS = 64;
  localparam int SLOT_BITS   = 6;
  localparam int LIVE_BITS   = 7;
  localparam int K_MAX       = 16;
  localparam int K_BITS      = 5;
  localparam int COUNT_BITS  = 16;
  localparam int STAMP_BITS  = 35;
  localparam int TIME_BITS   = 44;
  localparam int WIN_BITS    = 17;
  localparam int STEP_BITS   = 12;
  localparam int DIVR_BITS   = 22;
  localparam int THR_BITS    = 37;
  localparam int MS_PER_SEC  = 1000;
  localparam int TALLY_DEPTH = NUM_BUCKETS * NUM_WORDS;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [1:0] OP_HIT   = 2'd0;
  localparam logic [1:0] OP_EOM   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam logic REG_WINDOW = 1'b0;
  localparam logic REG_BUCKET = 1'b1;

  localparam logic [WIN_BITS-1:0] WIN_RESET  = 17'd60;
  localparam logic [WIN_BITS-1:0] WIN_OFF    = '1;
  localparam logic [STEP_BITS-1:0] STEP_RESET = 12'd1;

endpackage

### design/wtk_ifs.sv
interface wtk_cmd_if;
  import wtk_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [1:0]           op;
  logic [TIME_BITS-1:0] time_ms;
  logic [WORD_BITS-1:0] word_index;
  logic [K_BITS-1:0]    k_wanted;
  modport source (output valid, op, time_ms, word_index, k_wanted, input ready);
  modport sink (input valid, op, time_ms, word_index, k_wanted, output ready);
endinterface

interface wtk_rank_if;
  import wtk_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [WORD_BITS-1:0]  top_word;
  logic [COUNT_BITS-1:0] top_count;
  logic                  final_entry;
  logic                  ring_overflowed;
  modport source (output valid, top_word, top_count, final_entry, ring_overflowed,
                  input ready);
  modport sink (input valid, top_word, top_count, final_entry, ring_overflowed,
                output ready);
endinterface

### design/wtk_ram.sv
module wtk_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/wtk_div.sv
module wtk_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [wtk_pkg::TIME_BITS-1:0] dividend,
  input  logic [wtk_pkg::DIVR_BITS-1:0] divisor,
  output logic                          done,
  output logic [wtk_pkg::TIME_BITS-1:0] quotient
);
  import wtk_pkg::*;

  localparam int CNT_BITS = $clog2(TIME_BITS);

  logic                busy;
  logic [CNT_BITS-1:0] cnt;
  logic [DIVR_BITS-1:0] rem;
  logic [DIVR_BITS-1:0] dvs;
  logic [DIVR_BITS:0]   shifted;
  logic [DIVR_BITS:0]   diff;

  // restoring division, one quotient bit per cycle
  assign shifted = {rem, quotient[TIME_BITS-1]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= CNT_BITS'(TIME_BITS - 1);
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        if (!diff[DIVR_BITS]) begin
          rem      <= diff[DIVR_BITS-1:0];
          quotient <= {quotient[TIME_BITS-2:0], 1'b1};
        end else begin
          rem      <= shifted[DIVR_BITS-1:0];
          quotient <= {quotient[TIME_BITS-2:0], 1'b0};
        end
        cnt <= cnt - CNT_BITS'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### design/windowed_top_k_counter.sv
// channel  dir  handshake      payload
// cmd      in   valid/ready    op, time_ms, word_index, k_wanted
// rank     out  valid/ready    top_word, top_count, final_entry, ring_overflowed
// apb      in   psel/penable   window_seconds at 0x0, bucket_seconds at 0x4
//
// a hit passes through the serial divider that aligns the timestamp,
// then stamp read, bucket decision and tally/total read-modify-write
// opening a bucket adds a clear of its 256-word row; end of message checks the stamp
// of each oldest bucket and, per retired bucket, reads then writes each word
// a query walks the totals once per rank, one more walk if ranks run out
// reset is synchronous, per-word valid bits stand in for a clear pass of the
// totals; a stalled rank output holds the query walk and with it cmd ready
module windowed_top_k_counter (
  input  logic        clk,
  input  logic        rst,
  wtk_cmd_if.sink     cmd,
  wtk_rank_if.source  rank,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import wtk_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DIV     = 4'd1;
  localparam logic [3:0] S_MUL     = 4'd2;
  localparam logic [3:0] S_DECIDE  = 4'd3;
  localparam logic [3:0] S_CLEAR   = 4'd4;
  localparam logic [3:0] S_HIT_RD  = 4'd5;
  localparam logic [3:0] S_HIT_WR  = 4'd6;
  localparam logic [3:0] S_EXP_RD  = 4'd7;
  localparam logic [3:0] S_EXP_CHK = 4'd8;
  localparam logic [3:0] S_EXP_WRD = 4'd9;
  localparam logic [3:0] S_EXP_WWR = 4'd10;
  localparam logic [3:0] S_Q_SCAN  = 4'd11;
  localparam logic [3:0] S_Q_END   = 4'd12;
  localparam logic [3:0] S_Q_LAST  = 4'd13;

  localparam int TADDR_BITS = SLOT_BITS + WORD_BITS;

  // configuration registers
  logic [WIN_BITS-1:0]  window_sec;
  logic [STEP_BITS-1:0] bucket_sec;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_sec <= WIN_RESET;
      bucket_sec <= STEP_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_WINDOW: window_sec <= pwdata[WIN_BITS-1:0];
        REG_BUCKET: bucket_sec <= pwdata[STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WINDOW: prdata = {{(32-WIN_BITS){window_sec[WIN_BITS-1]}}, window_sec};
      REG_BUCKET: prdata = {{(32-STEP_BITS){1'b0}}, bucket_sec};
      default:    prdata = '0;
    endcase
  end

  // control and held request
  logic [3:0]           state;
  logic [1:0]           op_q;
  logic [WORD_BITS-1:0] word_q;
  logic [K_BITS-1:0]    k_eff;
  logic [K_BITS-1:0]    n_found;
  logic [STAMP_BITS-1:0] aligned;
  logic [SLOT_BITS-1:0] oldest;
  logic [LIVE_BITS-1:0] live;
  logic                 overflow;
  logic [SLOT_BITS-1:0] row;
  logic                 row_ok;
  logic [WORD_BITS:0]   cnt;

  // query walk
  logic                  scan_vld;
  logic [WORD_BITS-1:0]  scan_id;
  logic [COUNT_BITS-1:0] best_count;
  logic [WORD_BITS-1:0]  best_id;
  logic                  have_pend;
  logic [COUNT_BITS-1:0] pend_count;
  logic [WORD_BITS-1:0]  pend_id;

  // output register
  logic                  out_valid;
  logic [WORD_BITS-1:0]  out_word;
  logic [COUNT_BITS-1:0] out_count;
  logic                  out_final;
  logic                  out_ovf;
  logic                  slot_free;
  logic                  out_load;

  assign rank.valid           = out_valid;
  assign rank.top_word        = out_word;
  assign rank.top_count       = out_count;
  assign rank.final_entry     = out_final;
  assign rank.ring_overflowed = out_ovf;
  assign slot_free            = !out_valid || rank.ready;
  // a new rank enters the output register this cycle
  assign out_load = slot_free && ((state == S_Q_END && have_pend) || state == S_Q_LAST);

  assign cmd.ready = (state == S_IDLE);

  // where a request goes once its bucket is known
  logic       no_expiry;
  logic [3:0] after_find;

  assign no_expiry  = (window_sec == WIN_OFF);
  assign after_find = (op_q == OP_HIT) ? S_HIT_RD : (no_expiry ? S_IDLE : S_EXP_RD);

  // timestamp alignment: aligned = floor(ms / (1000*step)) * step
  logic [STEP_BITS-1:0]            step_eff;
  logic [DIVR_BITS-1:0]            divisor;
  logic                            div_start;
  logic                            div_done;
  logic [TIME_BITS-1:0]            quotient;
  logic [STAMP_BITS+STEP_BITS-1:0] prod;

  assign step_eff  = (bucket_sec == '0) ? STEP_BITS'(1) : bucket_sec;
  assign divisor   = step_eff * DIVR_BITS'(MS_PER_SEC);
  assign div_start = cmd.valid && cmd.ready && (cmd.op == OP_HIT || cmd.op == OP_EOM);
  assign prod      = quotient[STAMP_BITS-1:0] * step_eff;

  wtk_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cmd.time_ms),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // ring pointers
  logic [SLOT_BITS-1:0] newest;
  logic [SLOT_BITS-1:0] open_slot;
  logic                 ring_full;

  assign newest    = oldest + live[SLOT_BITS-1:0] - SLOT_BITS'(1);
  assign open_slot = oldest + live[SLOT_BITS-1:0];
  assign ring_full = (live == LIVE_BITS'(NUM_BUCKETS));

  // memories
  logic                  stamp_we;
  logic [SLOT_BITS-1:0]  stamp_raddr;
  logic [STAMP_BITS-1:0] stamp_rdata;
  logic                  tally_we;
  logic [TADDR_BITS-1:0] tally_waddr;
  logic [COUNT_BITS-1:0] tally_wdata;
  logic [TADDR_BITS-1:0] tally_raddr;
  logic [COUNT_BITS-1:0] tally_rdata;
  logic                  total_we;
  logic [WORD_BITS-1:0]  total_waddr;
  logic [COUNT_BITS-1:0] total_wdata;
  logic [WORD_BITS-1:0]  total_raddr;
  logic [COUNT_BITS-1:0] total_rdata;
  logic [NUM_WORDS-1:0]  total_vld;
  logic                  total_vld_q;
  logic [COUNT_BITS-1:0] total_val;

  assign total_val = total_vld_q ? total_rdata : '0;

  // bucket decision and expiry compare
  logic                       need_open;
  logic signed [THR_BITS-1:0] threshold;
  logic                       stamp_old;

  assign need_open = (live == '0) || (aligned > stamp_rdata);
  assign threshold = $signed({{(THR_BITS-STAMP_BITS){1'b0}}, aligned})
                   - $signed({{(THR_BITS-WIN_BITS){window_sec[WIN_BITS-1]}}, window_sec});
  assign stamp_old = $signed({{(THR_BITS-STAMP_BITS){1'b0}}, stamp_rdata}) <= threshold;

  // candidate test during the query walk
  logic scan_take;

  assign scan_take = scan_vld && (total_val != '0) && (total_val > best_count) &&
                     (!have_pend || total_val < pend_count ||
                      (total_val == pend_count && scan_id > pend_id));

  always_comb begin
    stamp_raddr = (state == S_EXP_RD) ? oldest : newest;
    tally_raddr = (state == S_HIT_RD) ? {row, word_q} : {oldest, cnt[WORD_BITS-1:0]};
    total_raddr = (state == S_HIT_RD) ? word_q : cnt[WORD_BITS-1:0];

    stamp_we    = (state == S_DECIDE) && need_open && !ring_full;
    tally_we    = 1'b0;
    tally_waddr = {row, cnt[WORD_BITS-1:0]};
    tally_wdata = '0;
    total_we    = 1'b0;
    total_waddr = cnt[WORD_BITS-1:0];
    total_wdata = '0;

    unique case (state)
      S_CLEAR: begin
        tally_we = 1'b1;
      end
      S_HIT_WR: begin
        tally_we    = row_ok && (tally_rdata != COUNT_MAX);
        tally_waddr = {row, word_q};
        tally_wdata = tally_rdata + COUNT_BITS'(1);
        total_we    = (total_val != COUNT_MAX);
        total_waddr = word_q;
        total_wdata = total_val + COUNT_BITS'(1);
      end
      S_EXP_WWR: begin
        total_we    = 1'b1;
        total_wdata = (total_val > tally_rdata) ? total_val - tally_rdata : '0;
      end
      default: ;
    endcase
  end

  wtk_ram #(.WIDTH(STAMP_BITS), .DEPTH(NUM_BUCKETS)) u_stamps (
    .clk   (clk),
    .we    (stamp_we),
    .waddr (open_slot),
    .wdata (aligned),
    .raddr (stamp_raddr),
    .rdata (stamp_rdata)
  );

  wtk_ram #(.WIDTH(COUNT_BITS), .DEPTH(TALLY_DEPTH)) u_tallies (
    .clk   (clk),
    .we    (tally_we),
    .waddr (tally_waddr),
    .wdata (tally_wdata),
    .raddr (tally_raddr),
    .rdata (tally_rdata)
  );

  wtk_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_WORDS)) u_totals (
    .clk   (clk),
    .we    (total_we),
    .waddr (total_waddr),
    .wdata (total_wdata),
    .raddr (total_raddr),
    .rdata (total_rdata)
  );

  // word totals never written since reset read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      total_vld <= '0;
    end else if (total_we) begin
      total_vld[total_waddr] <= 1'b1;
    end
    total_vld_q <= total_vld[total_raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      oldest    <= '0;
      live      <= '0;
      overflow  <= 1'b0;
      out_valid <= 1'b0;
      scan_vld  <= 1'b0;
      have_pend <= 1'b0;
    end else begin
      if (out_valid && rank.ready && !out_load) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            op_q   <= cmd.op;
            word_q <= cmd.word_index;
            k_eff  <= (cmd.k_wanted > K_BITS'(K_MAX)) ? K_BITS'(K_MAX) : cmd.k_wanted;
            priority if (cmd.op == OP_HIT || cmd.op == OP_EOM) begin
              state <= S_DIV;
            end else if (cmd.op == OP_QUERY && cmd.k_wanted != '0) begin
              n_found    <= '0;
              have_pend  <= 1'b0;
              best_count <= '0;
              cnt        <= '0;
              scan_vld   <= 1'b0;
              state      <= S_Q_SCAN;
            end
          end
        end

        S_DIV: begin
          if (div_done) begin
            state <= S_MUL;
          end
        end

        // stamp of the newest bucket is read here
        S_MUL: begin
          aligned <= prod[STAMP_BITS-1:0];
          state   <= S_DECIDE;
        end

        S_DECIDE: begin
          cnt <= '0;
          priority if (need_open && ring_full) begin
            overflow <= 1'b1;
            row_ok   <= 1'b0;
            state    <= after_find;
          end else if (need_open) begin
            row    <= open_slot;
            row_ok <= 1'b1;
            live   <= live + LIVE_BITS'(1);
            state  <= S_CLEAR;
          end else begin
            row    <= newest;
            row_ok <= 1'b1;
            state  <= after_find;
          end
        end

        // zero the new bucket's row, one word a cycle
        S_CLEAR: begin
          if (cnt[WORD_BITS-1:0] == '1) begin
            cnt   <= '0;
            state <= after_find;
          end else begin
            cnt <= cnt + (WORD_BITS+1)'(1);
          end
        end

        S_HIT_RD: state <= S_HIT_WR;
        S_HIT_WR: state <= S_IDLE;

        // oldest stamp is read here
        S_EXP_RD: begin
          cnt   <= '0;
          state <= (live == '0) ? S_IDLE : S_EXP_CHK;
        end

        S_EXP_CHK: begin
          state <= stamp_old ? S_EXP_WRD : S_IDLE;
        end

        S_EXP_WRD: state <= S_EXP_WWR;

        // subtract the retiring tally from the word total
        S_EXP_WWR: begin
          cnt <= cnt + (WORD_BITS+1)'(1);
          if (cnt[WORD_BITS-1:0] == '1) begin
            oldest <= oldest + SLOT_BITS'(1);
            live   <= live - LIVE_BITS'(1);
            state  <= S_EXP_RD;
          end else begin
            state <= S_EXP_WRD;
          end
        end

        // one pass over all totals finds the next rank
        S_Q_SCAN: begin
          if (scan_take) begin
            best_count <= total_val;
            best_id    <= scan_id;
          end
          if (!cnt[WORD_BITS]) begin
            scan_vld <= 1'b1;
            scan_id  <= cnt[WORD_BITS-1:0];
            cnt      <= cnt + (WORD_BITS+1)'(1);
          end else begin
            scan_vld <= 1'b0;
            state    <= S_Q_END;
          end
        end

        // the held rank goes out once it is known whether it is the last
        S_Q_END: begin
          if (slot_free) begin
            if (have_pend) begin
              out_valid <= 1'b1;
              out_word  <= pend_id;
              out_count <= pend_count;
              out_final <= (best_count == '0);
              out_ovf   <= overflow;
            end
            if (best_count == '0) begin
              state <= S_IDLE;
            end else begin
              pend_count <= best_count;
              pend_id    <= best_id;
              have_pend  <= 1'b1;
              n_found    <= n_found + K_BITS'(1);
              best_count <= '0;
              cnt        <= '0;
              state      <= (n_found + K_BITS'(1) == k_eff) ? S_Q_LAST : S_Q_SCAN;
            end
          end
        end

        S_Q_LAST: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_word  <= pend_id;
            out_count <= pend_count;
            out_final <= 1'b1;
            out_ovf   <= overflow;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
